FILE: src/lru_block_buffer_tags_defines.svh
// ----------------------------------------------------------------------------
// lru_block_buffer_tags_defines.svh
// assertion macros shared by the block buffer tag controller
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_TAGS_DEFINES_SVH
`define LRU_BLOCK_BUFFER_TAGS_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBBT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbbt: same-cycle check failed");

// next-cycle implication
`define LBBT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbbt: next-cycle check failed");

`else

`define LBBT_ASSERT_IMPL(label, ante, cons)
`define LBBT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/lbbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_pkg
// types and codes of the block buffer tag controller
// ----------------------------------------------------------------------------
package lbbt_pkg;

   localparam int IDX_W        = 32;
   localparam int SLOT_FIELD_W = 4;
   localparam int SLOT_MAX_W   = 8;

   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_POP    = 2'd1,
      OP_PUSH   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_DECIDE,
      ST_RANK,
      ST_RANK_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                  operation;
      logic [IDX_W-1:0]        block_index;
      logic                    index_valid;
      logic [SLOT_FIELD_W-1:0] slot;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot_out;
      logic [IDX_W-1:0]        old_index;
      logic                    old_index_valid;
      logic                    present_out;
   } rsp_type;

   // commands into the slot store
   typedef struct packed {
      logic                  rd_en;
      logic [SLOT_MAX_W-1:0] rd_addr;
      logic                  tag_we;
      logic                  flag_we;
      logic [SLOT_MAX_W-1:0] wr_addr;
      logic [IDX_W-1:0]      tag_wdata;
      logic                  tag_wvalid;
      logic                  in_table_w;
      logic                  listed_w;
      logic                  present_w;
      logic                  rank_we;
      logic [SLOT_MAX_W-1:0] rank_addr;
      logic [SLOT_MAX_W-1:0] rank_wdata;
   } store_cmd_type;

   // registered read data of one slot
   typedef struct packed {
      logic [IDX_W-1:0]      tag;
      logic                  tag_valid;
      logic                  in_table;
      logic                  listed;
      logic                  present;
      logic [SLOT_MAX_W-1:0] rank;
   } store_rd_type;

   // what the scan pass has gathered
   typedef struct packed {
      logic                  found;
      logic [SLOT_MAX_W-1:0] found_slot;
      logic                  found_present;
      logic [SLOT_MAX_W-1:0] found_rank;
      logic                  lru_any;
      logic [SLOT_MAX_W-1:0] lru_slot;
      logic [IDX_W-1:0]      lru_tag;
      logic                  lru_tag_valid;
      logic                  lru_present;
      logic [SLOT_MAX_W-1:0] lru_rank;
      logic [SLOT_MAX_W-1:0] target_rank;
   } scan_res_type;

endpackage

FILE: src/lru_block_buffer_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_buffer_tags
// Tag and recency controller for a fully associative buffer of NUM_BLOCKS
// block slots. Search finds the slot holding a block number (lowest slot on
// duplicates) and makes it most recent; pop takes the slot holding the number
// or else the least recent listed slot, and drops it from table and list;
// push tags a slot, lists it as most recent and sets its present flag. Every
// operation walks the slots once through a single registered read port of
// the tag and rank memories, one slot per cycle; search and push then walk
// the ranks a second time to move the chosen slot to the top (pop and a
// search miss skip this; an unused code or a push slot outside the buffer
// skips both walks). An accepted item holds the request side stalled until
// its result is loaded into the output register.
// A finished result sits in an output register, so the next request can be
// taken while it waits. No clearing pass after reset: ranks read as the slot
// number until first written.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_tags_defines.svh"

module lru_block_buffer_tags #(
   parameter int NUM_BLOCKS = 16,
   parameter int INDEX_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lbbt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbbt_pkg::rsp_type rsp_payload
);
   import lbbt_pkg::*;

   localparam int SLOT_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int TAG_W  = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
   localparam logic [IDX_W-1:0]  IDX_MASK  = IDX_W'((64'd1 << TAG_W) - 64'd1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BLOCKS - 1);

   // sequencer state
   state_type         state_ff,    state_in;
   logic [SLOT_W-1:0] cnt_ff,      cnt_in;
   logic              scan_d_ff,   scan_d_in;   // scan read data arrives
   logic              rank_d_ff,   rank_d_in;   // rank read data arrives
   logic [SLOT_W-1:0] rd_idx_ff,   rd_idx_in;   // slot of the arriving data

   // latched request
   op_type            op_ff,       op_in;
   logic [IDX_W-1:0]  idx_ff,      idx_in;
   logic              ivalid_ff,   ivalid_in;
   logic [SLOT_W-1:0] pslot_ff,    pslot_in;

   // chosen slot for the rank pass
   logic [SLOT_W-1:0] sel_ff,      sel_in;
   logic [SLOT_W-1:0] sel_rank_ff, sel_rank_in;

   // result being built, and output register
   rsp_type           res_ff,      res_in;
   rsp_type           rsp_ff,      rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   store_cmd_type     cmd;
   store_rd_type      rd;
   scan_res_type      sr;
   logic              scan_start;
   logic              accept;
   logic              slot_ok;
   logic              same_tag;
   logic [SLOT_W-1:0] rk;

   lbbt_store #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SLOT_W     (SLOT_W),
      .TAG_W      (TAG_W)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

   lbbt_scan #(
      .SLOT_W (SLOT_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .sample    (scan_d_ff),
      .slot_idx  (rd_idx_ff),
      .push_slot (pslot_ff),
      .req_index (idx_ff),
      .req_valid (ivalid_ff),
      .rd        (rd),
      .res       (sr)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // push slot must fall inside the buffer
   assign slot_ok = (32'(req_payload.slot) < NUM_BLOCKS);
   assign rk      = rd.rank[SLOT_W-1:0];
   // pop keeps present only when the slot's tag equals the request
   assign same_tag = (sr.lru_tag_valid == ivalid_ff) && (!ivalid_ff || (sr.lru_tag == idx_ff));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_d_in    = 1'b0;
      rank_d_in    = 1'b0;
      rd_idx_in    = cnt_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      ivalid_in    = ivalid_ff;
      pslot_in     = pslot_ff;
      sel_in       = sel_ff;
      sel_rank_in  = sel_rank_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      scan_start   = 1'b0;
      cmd          = '0;

      // rank pass data phase: chosen slot to the top, close the gap below
      if (rank_d_ff) begin
         cmd.rank_addr = SLOT_MAX_W'(rd_idx_ff);
         if (rd_idx_ff == sel_ff) begin
            cmd.rank_we    = 1'b1;
            cmd.rank_wdata = SLOT_MAX_W'(LAST_SLOT);
         end else if (rk > sel_rank_ff) begin
            cmd.rank_we    = 1'b1;
            cmd.rank_wdata = SLOT_MAX_W'(rk - 1'b1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_payload.operation;
               idx_in     = req_payload.block_index & IDX_MASK;
               ivalid_in  = req_payload.index_valid;
               pslot_in   = SLOT_W'(req_payload.slot);
               cnt_in     = '0;
               scan_start = 1'b1;
               res_in     = '0;
               unique case (req_payload.operation)
                  OP_SEARCH, OP_POP: begin
                     state_in = ST_SCAN;
                  end
                  OP_PUSH: begin
                     if (slot_ok) begin
                        state_in = ST_SCAN;
                     end else begin
                        res_in.status = STATUS_EMPTY;
                        state_in      = ST_FINISH;
                     end
                  end
                  default: begin
                     // unused code: all-zero result, no change
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = SLOT_MAX_W'(cnt_ff);
            scan_d_in   = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_SCAN_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_SCAN_WAIT: begin
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            cnt_in = '0;
            unique case (op_ff)
               OP_SEARCH: begin
                  if (sr.found) begin
                     sel_in             = sr.found_slot[SLOT_W-1:0];
                     sel_rank_in        = sr.found_rank[SLOT_W-1:0];
                     res_in.slot_out    = SLOT_FIELD_W'(sr.found_slot);
                     res_in.present_out = sr.found_present;
                     cmd.flag_we        = 1'b1;
                     cmd.wr_addr        = sr.found_slot;
                     cmd.in_table_w     = 1'b1;
                     cmd.listed_w       = 1'b1;
                     cmd.present_w      = sr.found_present;
                     state_in           = ST_RANK;
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                     state_in      = ST_FINISH;
                  end
               end
               OP_POP: begin
                  state_in = ST_FINISH;
                  if (sr.found) begin
                     // matching tag: present flag kept
                     res_in.slot_out        = SLOT_FIELD_W'(sr.found_slot);
                     res_in.old_index       = idx_ff;
                     res_in.old_index_valid = 1'b1;
                     res_in.present_out     = sr.found_present;
                     cmd.flag_we            = 1'b1;
                     cmd.wr_addr            = sr.found_slot;
                     cmd.present_w          = sr.found_present;
                  end else if (sr.lru_any) begin
                     res_in.slot_out        = SLOT_FIELD_W'(sr.lru_slot);
                     res_in.old_index       = sr.lru_tag_valid ? sr.lru_tag : '0;
                     res_in.old_index_valid = sr.lru_tag_valid;
                     res_in.present_out     = sr.lru_present && same_tag;
                     cmd.flag_we            = 1'b1;
                     cmd.wr_addr            = sr.lru_slot;
                     cmd.present_w          = sr.lru_present && same_tag;
                  end else begin
                     res_in.status = STATUS_EMPTY;
                  end
               end
               OP_PUSH: begin
                  sel_in             = pslot_ff;
                  sel_rank_in        = sr.target_rank[SLOT_W-1:0];
                  res_in.slot_out    = SLOT_FIELD_W'(pslot_ff);
                  res_in.present_out = 1'b1;
                  cmd.tag_we         = 1'b1;
                  cmd.flag_we        = 1'b1;
                  cmd.wr_addr        = SLOT_MAX_W'(pslot_ff);
                  cmd.tag_wdata      = ivalid_ff ? idx_ff : '0;
                  cmd.tag_wvalid     = ivalid_ff;
                  cmd.in_table_w     = ivalid_ff;
                  cmd.listed_w       = 1'b1;
                  cmd.present_w      = 1'b1;
                  state_in           = ST_RANK;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_RANK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = SLOT_MAX_W'(cnt_ff);
            rank_d_in   = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_RANK_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_RANK_WAIT: begin
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // load the output register once it is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_d_ff    <= 1'b0;
         rank_d_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_d_ff    <= scan_d_in;
         rank_d_ff    <= rank_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      ivalid_ff   <= ivalid_in;
      pslot_ff    <= pslot_in;
      sel_ff      <= sel_in;
      sel_rank_ff <= sel_rank_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // checks
   `LBBT_ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall)
   `LBBT_ASSERT_NEXT(a_rsp_drains, rsp_valid && !rsp_stall && state_ff != ST_FINISH, !rsp_valid)
   `LBBT_ASSERT_IMPL(a_rank_write_in_pass, cmd.rank_we, state_ff == ST_RANK || state_ff == ST_RANK_WAIT)

endmodule

FILE: src/lbbt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_store
// tag and rank memories plus per-slot flag bits, one registered read port
// ----------------------------------------------------------------------------
module lbbt_store #(
   parameter int NUM_BLOCKS = 16,
   parameter int SLOT_W     = 4,
   parameter int TAG_W      = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lbbt_pkg::store_cmd_type cmd,
   output lbbt_pkg::store_rd_type  rd
);
   import lbbt_pkg::*;

   logic [TAG_W-1:0]      tag_mem_ff  [NUM_BLOCKS];
   logic [SLOT_W-1:0]     rank_mem_ff [NUM_BLOCKS];

   logic [NUM_BLOCKS-1:0] tag_valid_ff;
   logic [NUM_BLOCKS-1:0] in_table_ff;
   logic [NUM_BLOCKS-1:0] listed_ff;
   logic [NUM_BLOCKS-1:0] present_ff;
   logic [NUM_BLOCKS-1:0] rank_wr_ff;

   logic [TAG_W-1:0]      tag_q_ff;
   logic [SLOT_W-1:0]     rank_q_ff;
   logic [SLOT_W-1:0]     addr_q_ff;
   logic                  tv_q_ff;
   logic                  it_q_ff;
   logic                  li_q_ff;
   logic                  pr_q_ff;
   logic                  rw_q_ff;

   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     wr_addr;
   logic [SLOT_W-1:0]     rank_addr;

   assign rd_addr   = cmd.rd_addr[SLOT_W-1:0];
   assign wr_addr   = cmd.wr_addr[SLOT_W-1:0];
   assign rank_addr = cmd.rank_addr[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.tag_we) begin
         tag_mem_ff[wr_addr] <= cmd.tag_wdata[TAG_W-1:0];
      end
      if (cmd.rd_en) begin
         tag_q_ff <= tag_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rank_we) begin
         rank_mem_ff[rank_addr] <= cmd.rank_wdata[SLOT_W-1:0];
      end
      if (cmd.rd_en) begin
         rank_q_ff <= rank_mem_ff[rd_addr];
      end
   end

   // flag bits, ranks read as slot number until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= '0;
         in_table_ff  <= '0;
         listed_ff    <= '1;
         present_ff   <= '0;
         rank_wr_ff   <= '0;
      end else begin
         if (cmd.tag_we) begin
            tag_valid_ff[wr_addr] <= cmd.tag_wvalid;
         end
         if (cmd.flag_we) begin
            in_table_ff[wr_addr] <= cmd.in_table_w;
            listed_ff[wr_addr]   <= cmd.listed_w;
            present_ff[wr_addr]  <= cmd.present_w;
         end
         if (cmd.rank_we) begin
            rank_wr_ff[rank_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         tv_q_ff   <= tag_valid_ff[rd_addr];
         it_q_ff   <= in_table_ff[rd_addr];
         li_q_ff   <= listed_ff[rd_addr];
         pr_q_ff   <= present_ff[rd_addr];
         rw_q_ff   <= rank_wr_ff[rd_addr];
         addr_q_ff <= rd_addr;
      end
   end

   always_comb begin
      rd.tag       = IDX_W'(tag_q_ff);
      rd.tag_valid = tv_q_ff;
      rd.in_table  = it_q_ff;
      rd.listed    = li_q_ff;
      rd.present   = pr_q_ff;
      rd.rank      = SLOT_MAX_W'(rw_q_ff ? rank_q_ff : addr_q_ff);
   end

endmodule

FILE: src/lbbt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbt_scan
// shared compare unit folding one slot per cycle into match and lru picks
// ----------------------------------------------------------------------------
module lbbt_scan #(
   parameter int SLOT_W = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          sample,
   input  logic [SLOT_W-1:0]             slot_idx,
   input  logic [SLOT_W-1:0]             push_slot,
   input  logic [lbbt_pkg::IDX_W-1:0]    req_index,
   input  logic                          req_valid,
   input  lbbt_pkg::store_rd_type        rd,
   output lbbt_pkg::scan_res_type        res
);
   import lbbt_pkg::*;

   scan_res_type res_ff;
   scan_res_type res_in;
   logic         match;

   always_comb begin
      res_in = res_ff;
      match  = req_valid && rd.in_table && rd.tag_valid && (rd.tag == req_index);
      if (start) begin
         res_in.found   = 1'b0;
         res_in.lru_any = 1'b0;
      end else if (sample) begin
         // first match wins, lowest slot
         if (match && !res_ff.found) begin
            res_in.found         = 1'b1;
            res_in.found_slot    = SLOT_MAX_W'(slot_idx);
            res_in.found_present = rd.present;
            res_in.found_rank    = rd.rank;
         end
         if (rd.listed && (!res_ff.lru_any || (rd.rank < res_ff.lru_rank))) begin
            res_in.lru_any       = 1'b1;
            res_in.lru_slot      = SLOT_MAX_W'(slot_idx);
            res_in.lru_tag       = rd.tag;
            res_in.lru_tag_valid = rd.tag_valid;
            res_in.lru_present   = rd.present;
            res_in.lru_rank      = rd.rank;
         end
         if (slot_idx == push_slot) begin
            res_in.target_rank = rd.rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
